// ===== sv/sseg_pkg.sv =====
// Shared types, constants and decode functions for the seven-segment scan shifter.
// Used by sseg_front, sseg_fifo, sseg_back and the top level; depends on nothing.
`default_nettype none

package sseg_pkg;

  localparam int VALUE_W = 14;
  localparam int POS_W   = 2;
  localparam int WORD_W  = 16;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int BCNT_W  = $clog2(WORD_W);
  localparam int PROD_W  = 2 * VALUE_W;
  localparam int SHIFT_W = 5;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;
  localparam logic [7:0]         SEL_BASE  = 8'h10;

  // Reciprocal of ten, exact for every quotient up to 9999
  localparam logic [VALUE_W-1:0] RECIP_TEN  = 14'd6554;
  localparam int                 SHIFT_TEN  = 16;

  localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd0;
  localparam logic [POS_W-1:0] POS_HUNDREDS  = 2'd1;
  localparam logic [POS_W-1:0] POS_TENS      = 2'd2;
  localparam logic [POS_W-1:0] POS_UNITS     = 2'd3;

  typedef struct packed {
    logic [7:0] seg;
    logic [7:0] sel;
  } word_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } fifo_stat_t;

  // Active-low segment pattern, dp in bit 7
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = 8'hFF;
    endcase
    return code;
  endfunction

  // Multiplier and shift that divide a value below 10000 by the place weight
  function automatic logic [VALUE_W-1:0] place_mul(input logic [POS_W-1:0] pos);
    logic [VALUE_W-1:0] m;
    unique case (pos)
      POS_THOUSANDS: m = 14'd8389;
      POS_HUNDREDS:  m = 14'd5243;
      POS_TENS:      m = 14'd6554;
      POS_UNITS:     m = 14'd1;
      default:       m = 14'd1;
    endcase
    return m;
  endfunction

  function automatic logic [SHIFT_W-1:0] place_shift(input logic [POS_W-1:0] pos);
    logic [SHIFT_W-1:0] s;
    unique case (pos)
      POS_THOUSANDS: s = 5'd23;
      POS_HUNDREDS:  s = 5'd19;
      POS_TENS:      s = 5'd16;
      POS_UNITS:     s = 5'd0;
      default:       s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sseg_front.sv =====
// Front end: accepts scan ticks, tracks the digit position, extracts the digit
// and builds the 16-bit segment/select word. Depends on sseg_pkg.
`default_nettype none

module sseg_front #(
  parameter int DIGIT_COUNT = 4
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [sseg_pkg::VALUE_W-1:0]  in_value,
  output logic                          push_valid,
  input  wire                           push_ready,
  output sseg_pkg::word_t               push_word
);
  import sseg_pkg::*;

  localparam logic [POS_W:0] COUNT = (POS_W + 1)'(DIGIT_COUNT);

  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_next;
  logic [POS_W-1:0]   pos_use;
  logic [POS_W:0]     pos_inc;

  logic               s0_valid;
  logic [VALUE_W-1:0] s0_value;
  logic [POS_W-1:0]   s0_pos;
  logic               s1_valid;
  logic [VALUE_W-1:0] s1_q;
  logic [POS_W-1:0]   s1_pos;
  logic               s2_valid;
  logic [VALUE_W-1:0] s2_q;
  logic [9:0]         s2_q10;
  logic [POS_W-1:0]   s2_pos;

  logic               adv0;
  logic               adv1;
  logic               adv2;
  logic               accept;
  logic [VALUE_W-1:0] value_clamped;
  logic [PROD_W-1:0]  prod0;
  logic [PROD_W-1:0]  prod1;
  logic [VALUE_W-1:0] rem;
  logic [3:0]         digit;

  assign adv2     = !s2_valid || push_ready;
  assign adv1     = !s1_valid || adv2;
  assign adv0     = !s0_valid || adv1;
  assign in_ready = adv0;
  assign accept   = in_valid && adv0;

  assign value_clamped = (in_value > VALUE_MAX) ? VALUE_MAX : in_value;

  // Position outside the scan range shows the thousands digit
  assign pos_use  = ({1'b0, pos} >= COUNT) ? POS_THOUSANDS : pos;
  assign pos_inc  = {1'b0, pos_use} + (POS_W + 1)'(1);
  assign pos_next = (pos_inc >= COUNT) ? POS_THOUSANDS : pos_inc[POS_W-1:0];

  assign prod0 = (PROD_W)'(s0_value) * (PROD_W)'(place_mul(s0_pos));
  assign prod1 = (PROD_W)'(s1_q) * (PROD_W)'(RECIP_TEN);

  // q - 10 * (q / 10)
  assign rem   = s2_q - {1'b0, s2_q10, 3'b000} - {3'b000, s2_q10, 1'b0};
  assign digit = rem[3:0];

  assign push_valid    = s2_valid;
  assign push_word.seg = seg_code(digit);
  assign push_word.sel = SEL_BASE << s2_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= POS_THOUSANDS;
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos <= pos_next;
      end
      if (adv0) begin
        s0_valid <= in_valid;
      end
      if (adv1) begin
        s1_valid <= s0_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_value <= value_clamped;
      s0_pos   <= pos_use;
    end
    if (adv1) begin
      s1_q   <= VALUE_W'(prod0 >> place_shift(s0_pos));
      s1_pos <= s0_pos;
    end
    if (adv2) begin
      s2_q   <= s1_q;
      s2_q10 <= prod1[SHIFT_TEN +: 10];
      s2_pos <= s1_pos;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sseg_fifo.sv =====
// Two-entry word queue between the front end and the serializer.
// Depends on sseg_pkg.
`default_nettype none

module sseg_fifo (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  sseg_pkg::word_t       push_word,
  input  wire                   pop,
  output sseg_pkg::word_t       pop_word,
  output sseg_pkg::fifo_stat_t  stat
);
  import sseg_pkg::*;

  word_t              entry [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign stat.count = count;
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_word   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_word;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sseg_back.sv =====
// Serializer: shifts each queued word out MSB first, one bit per request,
// flagging the sixteenth bit. Depends on sseg_pkg.
`default_nettype none

module sseg_back (
  input  wire                   clk,
  input  wire                   rst,
  input  sseg_pkg::fifo_stat_t  stat,
  input  sseg_pkg::word_t       pop_word,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  out_bit,
  output logic                  out_last
);
  import sseg_pkg::*;

  logic [WORD_W-1:0]  sreg;
  logic [BCNT_W-1:0]  left;
  logic               out_adv;

  assign out_adv = !out_valid || out_ready;
  assign pop     = out_adv && (left == '0) && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      left      <= '0;
    end else if (out_adv) begin
      if (left != '0) begin
        out_valid <= 1'b1;
        left      <= left - BCNT_W'(1);
      end else if (!stat.empty) begin
        out_valid <= 1'b1;
        left      <= BCNT_W'(WORD_W - 1);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      if (left != '0) begin
        out_bit  <= sreg[WORD_W-1];
        out_last <= (left == BCNT_W'(1));
        sreg     <= sreg << 1;
      end else if (!stat.empty) begin
        // load the next word and present its MSB at once
        out_bit  <= pop_word[WORD_W-1];
        out_last <= 1'b0;
        sreg     <= pop_word << 1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/seven_segment_scan_shift_out_unit.sv =====
// Four-digit multiplexed seven-segment scan driver with serial shift-out.
// Ticks queue up behind the serializer, which sends one bit per cycle while the
// receiver accepts; bits stream without gaps as long as words are queued.
// Reset: clears the pipeline, the word queue and the serializer, and returns
// the digit position to the thousands digit.
`default_nettype none

module seven_segment_scan_shift_out_unit #(
  parameter int DIGIT_COUNT = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [13:0] display_value
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] shift_bit
  output logic        m_axis_tlast    // latch_pulse
);
  import sseg_pkg::*;

  logic        push_valid;
  logic        push_ready;
  word_t       push_word;
  word_t       pop_word;
  logic        pop;
  fifo_stat_t  fifo_st;
  logic        out_bit;

  assign push_ready = !fifo_st.full;

  sseg_front #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_value   (s_axis_tdata[VALUE_W-1:0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word)
  );

  sseg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .stat      (fifo_st)
  );

  sseg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .stat      (fifo_st),
    .pop_word  (pop_word),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_bit   (out_bit),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, out_bit};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_st.count <= QCNT_W'(QDEPTH))
    else $error("word queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fifo_st.empty)
    else $error("serializer popped an empty queue");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> fifo_st.full)
    else $error("input stalled while the word queue had room");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (m_axis_tvalid && !m_axis_tlast))
    else $error("loaded word did not present its first bit");

endmodule

`default_nettype wire

// ===== verif/tb_seven_segment_scan_shift_out_unit.sv =====
// Self-checking bench for the four-digit seven-segment scan shifter: scan-tick
// requests go in, and each serial bit is compared with a built-in digit predictor.
// Depends on sseg_pkg and seven_segment_scan_shift_out_unit.
`default_nettype none

module tb_seven_segment_scan_shift_out_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sseg_pkg::*;

  localparam int DIGIT_COUNT  = 4;
  localparam int RANDOM_TICKS = 250;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AT      = 60;
  localparam int QUIET_FROM   = 120;
  localparam int QUIET_TO     = 180;
  localparam int DRAIN_CYCLES = 40;
  localparam int TICK_BITS    = 16;

  localparam logic [7:0] SEG_LUT [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };
  localparam int PLACE_WEIGHT [4] = '{1000, 100, 10, 1};

  typedef struct packed {
    logic shift_bit;
    logic latch_pulse;
  } serial_bit_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               known;
    logic [15:0]        word;
  } tick_row_t;

  // Digit position after reset is zero, so each row's position is its index mod 4
  tick_row_t tick_table [0:23] = '{
    '{14'd0,     1'b1, 16'hC010},
    '{14'd0,     1'b1, 16'hC020},
    '{14'd0,     1'b1, 16'hC040},
    '{14'd0,     1'b1, 16'hC080},
    '{14'd9999,  1'b1, 16'h9010},
    '{14'd9999,  1'b1, 16'h9020},
    '{14'd9999,  1'b1, 16'h9040},
    '{14'd9999,  1'b1, 16'h9080},
    '{14'd16383, 1'b1, 16'h9010},
    '{14'd10000, 1'b1, 16'h9020},
    '{14'd10000, 1'b1, 16'h9040},
    '{14'd16383, 1'b1, 16'h9080},
    '{14'd1234,  1'b0, 16'h0000},
    '{14'd5678,  1'b0, 16'h0000},
    '{14'd9012,  1'b0, 16'h0000},
    '{14'd3457,  1'b0, 16'h0000},
    '{14'd8000,  1'b0, 16'h0000},
    '{14'd2901,  1'b0, 16'h0000},
    '{14'd7345,  1'b0, 16'h0000},
    '{14'd4566,  1'b0, 16'h0000},
    '{14'd6789,  1'b0, 16'h0000},
    '{14'd8192,  1'b0, 16'h0000},
    '{14'd4096,  1'b0, 16'h0000},
    '{14'd9998,  1'b0, 16'h0000}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [13:0] display_value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [0] shift_bit
  logic        m_axis_tlast;        // latch_pulse

  serial_bit_t       pending_bits [$];
  serial_bit_t       head_bit;
  logic [POS_W-1:0]  scan_pos;
  int                ticks_sent;
  int                bits_seen;
  int                clamped_ticks;
  int                errors;
  int                idle_cycles;
  bit                quiet;
  bit                hold_done;

  seven_segment_scan_shift_out_unit #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk = ~clk;

  // Segment byte of the shown digit followed by the one-hot select byte
  function automatic logic [15:0] scan_word(input logic [VALUE_W-1:0] value,
                                            input logic [POS_W-1:0] pos);
    int v;
    int p;
    int digit;
    logic [7:0] sel;
    v = (value > 14'd9999) ? 9999 : int'(value);
    p = (int'(pos) >= DIGIT_COUNT) ? 0 : int'(pos);
    digit = (v / PLACE_WEIGHT[p]) % 10;
    sel = 8'h10 << p;
    return {SEG_LUT[digit], sel};
  endfunction

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos);
    int p;
    p = (int'(pos) >= DIGIT_COUNT) ? 0 : int'(pos);
    p = p + 1;
    if (p >= DIGIT_COUNT) begin
      p = 0;
    end
    return p[POS_W-1:0];
  endfunction

  // Queue the sixteen bits of an accepted tick, MSB first, latch on the last
  task automatic queue_tick(input logic [VALUE_W-1:0] value, input logic known,
                            input logic [15:0] typed_word);
    logic [15:0] word;
    serial_bit_t sb;
    word = known ? typed_word : scan_word(value, scan_pos);
    for (int k = 0; k < TICK_BITS; k++) begin
      sb.shift_bit   = word[15-k];
      sb.latch_pulse = (k == TICK_BITS - 1);
      pending_bits.push_back(sb);
    end
    if (value > 14'd9999) begin
      clamped_ticks++;
    end
    scan_pos = next_pos(scan_pos);
  endtask

  task automatic send_tick(input logic [VALUE_W-1:0] value, input logic known,
                           input logic [15:0] typed_word);
    int gap;
    gap = 0;
    while (!quiet && $urandom_range(99) < 34) begin
      gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, value};
    do @(posedge clk); while (!s_axis_tready);
    queue_tick(value, known, typed_word);
    ticks_sent++;
  endtask

  // Sink side: random stalls, one long hold-off, and a stretch with none
  initial begin
    forever begin
      @(posedge clk);
      if (!hold_done && ticks_sent >= HOLD_AT) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      bits_seen++;
      if (pending_bits.size() == 0) begin
        errors++;
        $display("%0t: unexpected bit: expected none, actual data=%h last=%b", $time,
                 m_axis_tdata, m_axis_tlast);
      end else begin
        head_bit = pending_bits.pop_front();
        if (m_axis_tdata !== {7'b0, head_bit.shift_bit}) begin
          errors++;
          $display("%0t: shift_bit mismatch: expected %h actual %h", $time,
                   {7'b0, head_bit.shift_bit}, m_axis_tdata);
        end
        if (m_axis_tlast !== head_bit.latch_pulse) begin
          errors++;
          $display("%0t: latch_pulse mismatch: expected %b actual %b", $time,
                   head_bit.latch_pulse, m_axis_tlast);
        end
      end
    end
  end

  // Give up once nothing moves on either side for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: no transfer for %0d cycles, %0d bits outstanding",
             STALL_LIMIT, pending_bits.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [VALUE_W-1:0] value;
    int r;
    scan_pos      = '0;
    ticks_sent    = 0;
    bits_seen     = 0;
    clamped_ticks = 0;
    errors        = 0;
    quiet         = 1'b0;
    hold_done     = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (tick_table[i]) begin
      send_tick(tick_table[i].value, tick_table[i].known, tick_table[i].word);
    end

    for (int n = 0; n < RANDOM_TICKS; n++) begin
      quiet = (n >= QUIET_FROM) && (n < QUIET_TO);
      r = $urandom_range(99);
      if (r < 80) begin
        value = VALUE_W'($urandom_range(9999));
      end else if (r < 90) begin
        value = VALUE_W'($urandom_range(16383, 10000));
      end else begin
        value = VALUE_W'($urandom_range(16383));
      end
      send_tick(value, 1'b0, 16'h0000);
    end
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_bits.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d scan ticks (%0d clamped above 9999), %0d serial bits checked",
             ticks_sent, clamped_ticks, bits_seen);
    $display("receiver hold-off of %0d cycles applied, %0d errors", HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/sseg_pkg.sv
sv/sseg_front.sv
sv/sseg_fifo.sv
sv/sseg_back.sv
sv/seven_segment_scan_shift_out_unit.sv
verif/tb_seven_segment_scan_shift_out_unit.sv
